@@ design/data_stack_unit_macros.svh @@
// Assertion helpers shared by the stack logic
`ifndef DATA_STACK_UNIT_MACROS_SVH
`define DATA_STACK_UNIT_MACROS_SVH

// Same-cycle implication, held off while in reset
`define DSU_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while in reset
`define DSU_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/dsu_pkg.sv @@
package dsu_pkg;

    localparam int WORD_W   = 32;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH = 3'd0,
        OP_POP  = 3'd1,
        OP_DUP  = 3'd2,
        OP_SWAP = 3'd3,
        OP_ROT  = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FEW      = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD      = 2'd0,
        CELL_FROM_UP   = 2'd1,
        CELL_FROM_DOWN = 2'd2
    } cell_cmd_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic dup;
        logic swap;
        logic rot;
    } row_ctrl_t;

endpackage

@@ design/dsu_cell.sv @@
module dsu_cell
    import dsu_pkg::*;
#(
    parameter int DATA_WIDTH = 32
)
(
    input  logic                  clk,
    input  cell_cmd_t             cmd,
    input  logic [DATA_WIDTH-1:0] up_in,
    input  logic [DATA_WIDTH-1:0] down_in,
    output logic [DATA_WIDTH-1:0] data
);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    always_comb
    begin
        case (cmd)
            CELL_FROM_UP:   data_next = up_in;
            CELL_FROM_DOWN: data_next = down_in;
            default:        data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

@@ design/dsu_ctrl.sv @@
`include "data_stack_unit_macros.svh"

module dsu_ctrl
    import dsu_pkg::*;
#(
    parameter int STACK_DEPTH = 256,
    localparam int CNT_W = $clog2(STACK_DEPTH + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [OP_W-1:0]   req_type,
    output row_ctrl_t         row,
    output logic [CNT_W-1:0]  count,
    output status_t           status,
    output logic              done
);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    status_t          status_reg;
    status_t          status_next;
    logic             done_reg;
    logic             empty;
    logic             full;
    logic             below2;
    logic             below3;

    assign empty  = (count_reg == '0);
    assign full   = (count_reg == CNT_W'(STACK_DEPTH));
    assign below2 = (count_reg < CNT_W'(2));
    assign below3 = (count_reg < CNT_W'(3));

    always_comb
    begin
        row         = '0;
        status_next = ST_OK;
        count_next  = count_reg;
        if (start)
        begin
            unique case (req_type)
                OP_PUSH:
                begin
                    if (full)
                        status_next = ST_OVERFLOW;
                    else
                    begin
                        row.push   = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                OP_POP:
                begin
                    if (empty)
                        status_next = ST_EMPTY;
                    else
                    begin
                        row.pop    = 1'b1;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                OP_DUP:
                begin
                    if (empty)
                        status_next = ST_EMPTY;
                    else if (full)
                        status_next = ST_OVERFLOW;
                    else
                    begin
                        row.dup    = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                OP_SWAP:
                begin
                    if (empty)
                        status_next = ST_EMPTY;
                    else if (below2)
                        status_next = ST_FEW;
                    else
                        row.swap = 1'b1;
                end
                OP_ROT:
                begin
                    if (empty)
                        status_next = ST_EMPTY;
                    else if (below3)
                        status_next = ST_FEW;
                    else
                        row.rot = 1'b1;
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            status_reg <= ST_OK;
            done_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= start;
            if (start)
                status_reg <= status_next;
        end
    end

    assign count  = count_reg;
    assign status = status_reg;
    assign done   = done_reg;

    `DSU_ASSERT_IMP(a_err_keeps_count, clk, rst_n, done_reg && (status_reg != ST_OK), count_reg == $past(count_reg), "failed operation changed the depth")
    `DSU_ASSERT_IMP(a_overflow_full, clk, rst_n, done_reg && (status_reg == ST_OVERFLOW), count_reg == CNT_W'(STACK_DEPTH), "overflow reported below full depth")
    `DSU_ASSERT_IMP(a_empty_zero, clk, rst_n, done_reg && (status_reg == ST_EMPTY), count_reg == '0, "empty reported on a non-empty stack")
    `DSU_ASSERT_NXT(a_push_grows, clk, rst_n, start && (req_type == OP_PUSH) && !full, count_reg == $past(count_reg) + CNT_W'(1), "push did not grow the depth")
    `DSU_ASSERT_NXT(a_pop_shrinks, clk, rst_n, start && (req_type == OP_POP) && !empty, count_reg == $past(count_reg) - CNT_W'(1), "pop did not shrink the depth")

endmodule

@@ design/data_stack_unit.sv @@
// Channel   Handshake              Ports
// -------   --------------------   ----------------------------------
// request   start high, busy low   req_type, push_value
// result    done strobe, 1 cycle   status, top_value, depth
//
// One word per cycle: busy stays low, so a request may follow every clock.
// The result appears in the cycle after acceptance, on the done strobe.
// The entries live in a row of cells, top of stack in cell 0; each
// operation shifts the row up or down, or permutes its top two or three cells.
// Reset clears the depth count, status and done; cell contents are left unset.
// The receiver cannot stall: each result is flagged by done for a single cycle.
module data_stack_unit
    import dsu_pkg::*;
#(
    parameter int STACK_DEPTH = 256,
    parameter int DATA_WIDTH  = 32,
    localparam int CNT_W = $clog2(STACK_DEPTH + 1)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [OP_W-1:0]     req_type,
    input  logic [WORD_W-1:0]   push_value,
    output logic                done,
    output logic [STATUS_W-1:0] status,
    output logic [WORD_W-1:0]   top_value,
    output logic [CNT_W-1:0]    depth
);

    row_ctrl_t             row;
    status_t               status_q;
    logic [CNT_W-1:0]      count_q;
    logic [DATA_WIDTH-1:0] push_data;
    logic [DATA_WIDTH-1:0] cell_q [STACK_DEPTH];

    assign push_data = DATA_WIDTH'(push_value);

    dsu_ctrl #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .row      (row),
        .count    (count_q),
        .status   (status_q),
        .done     (done)
    );

    for (genvar i = 0; i < STACK_DEPTH; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] up_w;
        logic [DATA_WIDTH-1:0] down_w;
        cell_cmd_t             cmd;

        if (i == 0)
        begin : g_up_top
            assign up_w = push_data;
        end
        else if (i == 2)
        begin : g_up_rot
            // rot drops the top word into the third cell
            assign up_w = row.rot ? cell_q[0] : cell_q[1];
        end
        else
        begin : g_up_mid
            assign up_w = cell_q[i-1];
        end

        if (i == STACK_DEPTH - 1)
        begin : g_down_end
            assign down_w = '0;
        end
        else
        begin : g_down_mid
            assign down_w = cell_q[i+1];
        end

        always_comb
        begin
            cmd = CELL_HOLD;
            if (row.push)
                cmd = CELL_FROM_UP;
            else if (row.dup)
                cmd = (i == 0) ? CELL_HOLD : CELL_FROM_UP;
            else if (row.pop)
                cmd = CELL_FROM_DOWN;
            else if (row.swap)
            begin
                if (i == 0)
                    cmd = CELL_FROM_DOWN;
                else if (i == 1)
                    cmd = CELL_FROM_UP;
            end
            else if (row.rot)
            begin
                if (i == 0 || i == 1)
                    cmd = CELL_FROM_DOWN;
                else if (i == 2)
                    cmd = CELL_FROM_UP;
            end
        end

        dsu_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .clk     (clk),
            .cmd     (cmd),
            .up_in   (up_w),
            .down_in (down_w),
            .data    (cell_q[i])
        );
    end

    assign busy      = 1'b0;
    assign status    = status_q;
    assign depth     = count_q;
    assign top_value = (count_q == '0) ? '0 : WORD_W'(cell_q[0]);

endmodule

@@ tb/sv/tb_data_stack_unit.sv @@
module tb_data_stack_unit;
    import dsu_pkg::*;

    localparam int STACK_LIMIT = 256;
    localparam int DEPTH_W     = 9;
    localparam int STALL_LIMIT = 4000;

    typedef struct {
        status_t              status;
        logic [WORD_W-1:0]    top;
        logic [DEPTH_W-1:0]   depth;
    } stack_view_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [OP_W-1:0]     req_type = '0;
    logic [WORD_W-1:0]   push_value = '0;
    logic                done;
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]   top_value;
    logic [DEPTH_W-1:0]  depth;

    logic [WORD_W-1:0]   held_words [STACK_LIMIT];
    int unsigned         held_count = 0;
    stack_view_t         pending_views [$];
    int unsigned         mismatch_count = 0;
    int unsigned         burst_left = 0;
    int unsigned         stall_cycles = 0;

    data_stack_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req_type   (req_type),
        .push_value (push_value),
        .done       (done),
        .status     (status),
        .top_value  (top_value),
        .depth      (depth)
    );

    always #1 clk = ~clk;

    function automatic stack_view_t apply_op(logic [OP_W-1:0] op, logic [WORD_W-1:0] val);
        stack_view_t       v;
        logic [WORD_W-1:0] t;
        v.status = ST_OK;
        case (op)
            OP_PUSH:
                if (held_count >= STACK_LIMIT)
                    v.status = ST_OVERFLOW;
                else
                begin
                    held_words[held_count] = val;
                    held_count++;
                end
            OP_POP:
                if (held_count == 0)
                    v.status = ST_EMPTY;
                else
                    held_count--;
            OP_DUP:
                if (held_count == 0)
                    v.status = ST_EMPTY;
                else if (held_count >= STACK_LIMIT)
                    v.status = ST_OVERFLOW;
                else
                begin
                    held_words[held_count] = held_words[held_count-1];
                    held_count++;
                end
            OP_SWAP:
                if (held_count == 0)
                    v.status = ST_EMPTY;
                else if (held_count < 2)
                    v.status = ST_FEW;
                else
                begin
                    t = held_words[held_count-1];
                    held_words[held_count-1] = held_words[held_count-2];
                    held_words[held_count-2] = t;
                end
            OP_ROT:
                if (held_count == 0)
                    v.status = ST_EMPTY;
                else if (held_count < 3)
                    v.status = ST_FEW;
                else
                begin
                    t = held_words[held_count-1];
                    held_words[held_count-1] = held_words[held_count-2];
                    held_words[held_count-2] = held_words[held_count-3];
                    held_words[held_count-3] = t;
                end
            default:
                ;
        endcase
        v.depth = held_count[DEPTH_W-1:0];
        v.top   = (held_count == 0) ? '0 : held_words[held_count-1];
        return v;
    endfunction

    function automatic logic [OP_W-1:0] pick_op(int unsigned w_push, int unsigned w_pop,
                                                 int unsigned w_dup, int unsigned w_swap,
                                                 int unsigned w_rot, int unsigned w_junk);
        int unsigned r;
        r = $urandom_range(w_push + w_pop + w_dup + w_swap + w_rot + w_junk - 1, 0);
        if (r < w_push)
            return OP_PUSH;
        r -= w_push;
        if (r < w_pop)
            return OP_POP;
        r -= w_pop;
        if (r < w_dup)
            return OP_DUP;
        r -= w_dup;
        if (r < w_swap)
            return OP_SWAP;
        r -= w_swap;
        if (r < w_rot)
            return OP_ROT;
        return OP_W'($urandom_range(7, 5));
    endfunction

    task automatic pace();
        if (burst_left > 0)
            burst_left--;
        else
        begin
            start      <= 1'b0;
            req_type   <= OP_W'($urandom);
            push_value <= $urandom;
            repeat ($urandom_range(6, 1)) @(posedge clk);
            burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(40, 20)
                                                     : $urandom_range(8, 0);
        end
    endtask

    task automatic send_word(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] val);
        start      <= 1'b1;
        req_type   <= op;
        push_value <= val;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_views.push_back(apply_op(op, val));
        pace();
    endtask

    task automatic wait_drained();
        if (pending_views.size() != 0)
        begin
            start <= 1'b0;
            while (pending_views.size() != 0)
                @(posedge clk);
        end
    endtask

    task automatic test_empty_stack();
        send_word(OP_POP, 32'h0);
        send_word(OP_DUP, 32'hFFFF_FFFF);
        send_word(OP_SWAP, 32'h0);
        send_word(OP_ROT, 32'h0);
        send_word(3'd5, 32'h1234_5678);
        send_word(3'd6, 32'h0);
        send_word(3'd7, 32'hFFFF_FFFF);
    endtask

    task automatic test_shuffle_ops();
        send_word(OP_PUSH, 32'h0000_0000);
        send_word(OP_SWAP, 32'h0);
        send_word(OP_ROT, 32'h0);
        send_word(OP_PUSH, 32'hFFFF_FFFF);
        send_word(OP_ROT, 32'h0);
        send_word(OP_SWAP, 32'h0);
        send_word(OP_POP, 32'h0);
        send_word(OP_DUP, 32'h0);
        send_word(OP_PUSH, 32'hA5A5_A5A5);
        send_word(OP_PUSH, 32'h5A5A_5A5A);
        send_word(OP_ROT, 32'h0);
        send_word(OP_ROT, 32'h0);
        send_word(OP_SWAP, 32'h0);
        send_word(3'd7, 32'hDEAD_BEEF);
        send_word(OP_DUP, 32'h0);
        send_word(OP_ROT, 32'h0);
        while (held_count > 0)
            send_word(OP_POP, $urandom);
    endtask

    task automatic test_full_stack();
        while (held_count < STACK_LIMIT)
            send_word(pick_op(70, 0, 20, 5, 5, 0), $urandom);
        send_word(OP_PUSH, $urandom);
        send_word(OP_DUP, $urandom);
        send_word(OP_SWAP, $urandom);
        send_word(OP_ROT, $urandom);
        send_word(3'd5, $urandom);
        send_word(OP_POP, $urandom);
        send_word(OP_DUP, $urandom);
        send_word(OP_DUP, $urandom);
        repeat (40)
        begin
            if (held_count < STACK_LIMIT - 6)
                send_word(pick_op(50, 10, 20, 8, 8, 4), $urandom);
            else
                send_word(pick_op(25, 25, 20, 12, 12, 6), $urandom);
        end
        while (held_count > 0)
            send_word(pick_op(4, 90, 2, 2, 2, 0), $urandom);
    endtask

    task automatic test_random_walk();
        repeat (100)
        begin
            if (held_count > 6)
                send_word(pick_op(10, 50, 5, 15, 15, 5), $urandom);
            else
                send_word(pick_op(30, 20, 12, 15, 18, 5), $urandom);
        end
    endtask

    task automatic note_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s", what);
    endtask

    always @(posedge clk)
    begin
        stack_view_t want;
        if (rst_n && done)
        begin
            if (pending_views.size() == 0)
                note_mismatch($sformatf("unexpected word: status %0d top %h depth %0d",
                                        status, top_value, depth));
            else
            begin
                want = pending_views.pop_front();
                if (status !== want.status || top_value !== want.top || depth !== want.depth)
                    note_mismatch($sformatf(
                        "mismatch: status exp %0d got %0d, top exp %h got %h, depth exp %0d got %0d",
                        want.status, status, want.top, top_value, want.depth, depth));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb_data_stack_unit: done, errors");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_stack();
        test_shuffle_ops();
        wait_drained();
        test_full_stack();
        test_random_walk();
        wait_drained();
        repeat (6) @(posedge clk);
        if (mismatch_count == 0 && pending_views.size() == 0)
            $display("tb_data_stack_unit: done, clean");
        else
            $display("tb_data_stack_unit: done, errors");
        $finish;
    end

endmodule
